### hdl/vdm_pkg.sv
package vdm_pkg;

    localparam int unsigned LevelWidth   = 7;
    localparam int unsigned ChannelWidth = 4;
    localparam int unsigned NumSources   = 3;

    typedef logic [LevelWidth-1:0]   level_t;
    typedef logic [ChannelWidth-1:0] channel_t;

    typedef enum logic [1:0] {
        SRC_BELLOWS   = 2'd0,
        SRC_MELODY    = 2'd1,
        SRC_BASSCHORD = 2'd2,
        SRC_NONE      = 2'd3
    } source_t;

    typedef enum logic {
        OP_SET     = 1'b0,
        OP_REFRESH = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        REG_MIN_DIFFERENCE = 3'd0,
        REG_FULL_VOLUME    = 3'd1,
        REG_MELODY_CHAN_A  = 3'd2,
        REG_MELODY_CHAN_B  = 3'd3,
        REG_MELODY_CHAN_C  = 3'd4,
        REG_MELODY_CHAN_D  = 3'd5,
        REG_BASS_CHAN      = 3'd6,
        REG_CHORD_CHAN     = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        BEAT_MEL_A = 3'd0,
        BEAT_MEL_B = 3'd1,
        BEAT_MEL_C = 3'd2,
        BEAT_MEL_D = 3'd3,
        BEAT_BASS  = 3'd4,
        BEAT_CHORD = 3'd5
    } beat_t;

    localparam level_t   RstMinDifference = level_t'(2);
    localparam level_t   RstFullVolume    = level_t'(127);
    localparam channel_t RstMelodyChanA   = channel_t'(0);
    localparam channel_t RstMelodyChanB   = channel_t'(4);
    localparam channel_t RstMelodyChanC   = channel_t'(5);
    localparam channel_t RstMelodyChanD   = channel_t'(6);
    localparam channel_t RstBassChan      = channel_t'(1);
    localparam channel_t RstChordChan     = channel_t'(3);

    function automatic logic moved_enough(level_t sent, level_t cur, level_t min_diff);
        level_t diff;
        diff = (sent > cur) ? level_t'(sent - cur) : level_t'(cur - sent);
        return diff >= min_diff;
    endfunction

    function automatic level_t average(level_t a, level_t b);
        logic [LevelWidth:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LevelWidth:1];
    endfunction

endpackage

### hdl/volume_deadband_mixer.sv
// Volume deadband mixer.
// Input channel (in_valid/in_ready): one beat either sets the volume of one
// source (bellows, melody, bass/chord) or requests a forced refresh. The
// source state and last-sent levels are updated in the cycle the beat is
// accepted; the resulting messages are loaded into the result register.
// Output channel (out_valid/out_ready): zero to six beats per input, one per
// cycle while the receiver is ready: melody channels a..d, then bass, then
// chord; last marks the final. The first message appears in the cycle after
// the input is accepted. The next input is taken in the same cycle as the
// final beat of the previous one, so inputs that cause no message run at one
// per cycle while no beat is pending.
// Configuration channel (cfg_valid/cfg_ready): always ready, register index
// and data; the user writes only while idle; the block does not enforce it.
// Reset clears all volumes, valid bits and last-sent levels and loads the
// register defaults; no message is sent until all three sources are written.
// When the receiver stalls, the current beat holds and input is refused
// until the final beat of the pending item is taken.
module volume_deadband_mixer
    import vdm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [LevelWidth-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    opcode,
    input  logic [1:0]              source,
    input  logic [LevelWidth-1:0]   level,
    input  logic                    bellows_enabled,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ChannelWidth-1:0] channel,
    output logic [LevelWidth-1:0]   volume,
    output logic                    last
);

    level_t   min_difference_reg;
    level_t   full_volume_reg;
    channel_t melody_chan_a_reg;
    channel_t melody_chan_b_reg;
    channel_t melody_chan_c_reg;
    channel_t melody_chan_d_reg;
    channel_t bass_chan_reg;
    channel_t chord_chan_reg;

    level_t   current_level_reg [NumSources];
    logic     level_valid_reg   [NumSources];
    level_t   sent_level_reg    [NumSources];
    logic     all_ready_reg;

    level_t   current_level_next [NumSources];
    logic     level_valid_next   [NumSources];
    level_t   sent_level_next    [NumSources];
    logic     all_ready_next;

    logic     pend_mel_reg, pend_mel_next;
    logic     pend_bc_reg,  pend_bc_next;
    beat_t    beat_reg,     beat_next;
    level_t   vol_mel_reg,  vol_mel_next;
    level_t   vol_bc_reg,   vol_bc_next;

    logic     in_fire;
    logic     out_fire;
    logic     is_set;
    logic     run;
    logic     valid_all;
    logic     bel_moved, mel_moved, bc_moved;
    logic     send_mel, send_bc;
    level_t   bel, mel, bc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_difference_reg <= RstMinDifference;
            full_volume_reg    <= RstFullVolume;
            melody_chan_a_reg  <= RstMelodyChanA;
            melody_chan_b_reg  <= RstMelodyChanB;
            melody_chan_c_reg  <= RstMelodyChanC;
            melody_chan_d_reg  <= RstMelodyChanD;
            bass_chan_reg      <= RstBassChan;
            chord_chan_reg     <= RstChordChan;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_DIFFERENCE: min_difference_reg <= cfg_data;
                REG_FULL_VOLUME:    full_volume_reg    <= cfg_data;
                REG_MELODY_CHAN_A:  melody_chan_a_reg  <= cfg_data[ChannelWidth-1:0];
                REG_MELODY_CHAN_B:  melody_chan_b_reg  <= cfg_data[ChannelWidth-1:0];
                REG_MELODY_CHAN_C:  melody_chan_c_reg  <= cfg_data[ChannelWidth-1:0];
                REG_MELODY_CHAN_D:  melody_chan_d_reg  <= cfg_data[ChannelWidth-1:0];
                REG_BASS_CHAN:      bass_chan_reg      <= cfg_data[ChannelWidth-1:0];
                REG_CHORD_CHAN:     chord_chan_reg     <= cfg_data[ChannelWidth-1:0];
                default: ;
            endcase
        end
    end

    assign out_valid = pend_mel_reg | pend_bc_reg;
    assign out_fire  = out_valid & out_ready;
    assign in_ready  = !out_valid | (out_ready & last);
    assign in_fire   = in_valid & in_ready;

    always_comb
    begin
        unique case (beat_reg)
            BEAT_MEL_A: channel = melody_chan_a_reg;
            BEAT_MEL_B: channel = melody_chan_b_reg;
            BEAT_MEL_C: channel = melody_chan_c_reg;
            BEAT_MEL_D: channel = melody_chan_d_reg;
            BEAT_BASS:  channel = bass_chan_reg;
            BEAT_CHORD: channel = chord_chan_reg;
            default:    channel = chord_chan_reg;
        endcase
    end

    assign volume = (beat_reg == BEAT_BASS || beat_reg == BEAT_CHORD) ? vol_bc_reg
                                                                       : vol_mel_reg;
    assign last   = (beat_reg == BEAT_CHORD) || (beat_reg == BEAT_MEL_D && !pend_bc_reg);

    // update the source state for the accepted beat and step the output beats
    always_comb
    begin
        is_set = (opcode_t'(opcode) == OP_SET);
        for (int i = 0; i < NumSources; i++)
        begin
            current_level_next[i] = current_level_reg[i];
            level_valid_next[i]   = level_valid_reg[i];
            sent_level_next[i]    = sent_level_reg[i];
            if (is_set && source == 2'(i))
            begin
                current_level_next[i] = level;
                level_valid_next[i]   = 1'b1;
            end
        end

        valid_all = level_valid_next[SRC_BELLOWS] & level_valid_next[SRC_MELODY]
                  & level_valid_next[SRC_BASSCHORD];
        run = in_fire && !(is_set && source_t'(source) == SRC_NONE)
              && (all_ready_reg || valid_all);
        all_ready_next = all_ready_reg | run;

        bel = bellows_enabled ? current_level_next[SRC_BELLOWS] : full_volume_reg;
        mel = current_level_next[SRC_MELODY];
        bc  = current_level_next[SRC_BASSCHORD];

        bel_moved = moved_enough(sent_level_reg[SRC_BELLOWS], bel, min_difference_reg);
        mel_moved = moved_enough(sent_level_reg[SRC_MELODY], mel, min_difference_reg);
        bc_moved  = moved_enough(sent_level_reg[SRC_BASSCHORD], bc, min_difference_reg);

        send_mel = run && (bel_moved || mel_moved || !is_set);
        send_bc  = run && (bel_moved || bc_moved || !is_set);

        if (send_mel || send_bc)
            sent_level_next[SRC_BELLOWS] = bel;
        if (send_mel)
            sent_level_next[SRC_MELODY] = mel;
        if (send_bc)
            sent_level_next[SRC_BASSCHORD] = bc;

        pend_mel_next = pend_mel_reg;
        pend_bc_next  = pend_bc_reg;
        beat_next     = beat_reg;
        vol_mel_next  = vol_mel_reg;
        vol_bc_next   = vol_bc_reg;

        if (out_fire)
        begin
            if (last)
            begin
                pend_mel_next = 1'b0;
                pend_bc_next  = 1'b0;
            end
            else
            begin
                beat_next = beat_t'(beat_reg + 3'd1);
            end
        end

        if (in_fire)
        begin
            pend_mel_next = send_mel;
            pend_bc_next  = send_bc;
            beat_next     = send_mel ? BEAT_MEL_A : BEAT_BASS;
            vol_mel_next  = bellows_enabled ? average(bel, mel) : mel;
            vol_bc_next   = bellows_enabled ? average(bel, bc) : bc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumSources; i++)
            begin
                current_level_reg[i] <= '0;
                level_valid_reg[i]   <= 1'b0;
                sent_level_reg[i]    <= '0;
            end
            all_ready_reg <= 1'b0;
            pend_mel_reg  <= 1'b0;
            pend_bc_reg   <= 1'b0;
            beat_reg      <= BEAT_MEL_A;
        end
        else
        begin
            if (in_fire)
            begin
                for (int i = 0; i < NumSources; i++)
                begin
                    current_level_reg[i] <= current_level_next[i];
                    level_valid_reg[i]   <= level_valid_next[i];
                    sent_level_reg[i]    <= sent_level_next[i];
                end
            end
            all_ready_reg <= all_ready_next;
            pend_mel_reg  <= pend_mel_next;
            pend_bc_reg   <= pend_bc_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vol_mel_reg <= vol_mel_next;
        vol_bc_reg  <= vol_bc_next;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!out_valid || (out_ready && last)))
        else $error("input taken while results still pending");

    a_bc_only_beats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pend_mel_reg) |-> (beat_reg == BEAT_BASS || beat_reg == BEAT_CHORD))
        else $error("melody beat without melody group pending");

    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(all_ready_reg))
        else $error("all_ready cleared outside reset");

    a_send_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (send_mel || send_bc)) |=> all_ready_reg)
        else $error("message sent before all sources valid");

endmodule
